// ----- hdl/svsi_pkg.sv -----
package svsi_pkg;

  localparam int MAX_SEGMENTS    = 1024;
  localparam int COORD_FRAC_BITS = 14;

  localparam int CNT_W   = 11;
  localparam int IDX_W   = 21;
  localparam int COORD_W = 16;
  localparam int ANG_W   = 32;
  localparam int TRIG_W  = 32;
  localparam int FRAC_Q  = 30;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 2;

  localparam int DIV_W              = 44;
  localparam int DIVISOR_W          = 12;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;

  localparam int SERIES_TERMS = 6;
  localparam int SC_LAT       = 3 + 3 * SERIES_TERMS + 2;
  localparam int PIPE_DEPTH   = DIV_STAGES + SC_LAT + 3;
  localparam int SIDE_LEN     = PIPE_DEPTH - 1;

  localparam int XZ_SHIFT = 2 * FRAC_Q - COORD_FRAC_BITS;
  localparam int Y_SHIFT  = FRAC_Q - COORD_FRAC_BITS;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  localparam logic [7:0] SIN_DEN [SERIES_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DEN [SERIES_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  localparam logic [30:0] SIN_RCP [SERIES_TERMS] = '{
    31'(64'h8000_0000 / 64'd156), 31'(64'h8000_0000 / 64'd110),
    31'(64'h8000_0000 / 64'd72),  31'(64'h8000_0000 / 64'd42),
    31'(64'h8000_0000 / 64'd20),  31'(64'h8000_0000 / 64'd6)};
  localparam logic [30:0] COS_RCP [SERIES_TERMS] = '{
    31'(64'h8000_0000 / 64'd132), 31'(64'h8000_0000 / 64'd90),
    31'(64'h8000_0000 / 64'd56),  31'(64'h8000_0000 / 64'd30),
    31'(64'h8000_0000 / 64'd12),  31'(64'h8000_0000 / 64'd2)};

  typedef enum logic [0:0] {
    REG_COLUMN_COUNT = 1'b0,
    REG_RING_COUNT   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic             vld;
    logic             vertex_valid;
    logic             strip_valid;
    logic [IDX_W-1:0] upper;
    logic [IDX_W-1:0] lower;
  } side_t;

endpackage

// ----- hdl/svsi_div.sv -----
module svsi_div import svsi_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic [ANG_W-1:0]     quotient
);

  logic [DIVISOR_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_W-1:0]     num_q [DIV_STAGES-1];
  logic [ANG_W-1:0]     quo_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DIVISOR_W-1:0] rem_in;
    logic [DIVISOR_W-1:0] rem_out;
    logic [DIV_W-1:0]     num_in;
    logic [DIV_W-1:0]     num_out;
    logic [ANG_W-1:0]     quo_in;
    logic [ANG_W-1:0]     quo_out;
    logic [DIVISOR_W:0]   trial;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign num_in = num_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    // restoring steps, one quotient bit each
    always_comb begin
      rem_out = rem_in;
      num_out = num_in;
      quo_out = quo_in;
      trial   = '0;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
        trial   = {rem_out, num_out[DIV_W-1]};
        num_out = {num_out[DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem_out = DIVISOR_W'(trial - {1'b0, divisor});
          quo_out = {quo_out[ANG_W-2:0], 1'b1};
        end else begin
          rem_out = trial[DIVISOR_W-1:0];
          quo_out = {quo_out[ANG_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= rem_out;
        quo_q[g] <= quo_out;
      end
    end

    if (g < DIV_STAGES - 1) begin : g_num
      always_ff @(posedge clk) begin
        if (en) begin
          num_q[g] <= num_out;
        end
      end
    end
  end

  assign quotient = quo_q[DIV_STAGES-1];

endmodule

// ----- hdl/svsi_sincos.sv -----
module svsi_sincos import svsi_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ANG_W-1:0]         angle,
  output logic signed [TRIG_W-1:0] sine,
  output logic signed [TRIG_W-1:0] cosine
);

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
  } ctx_t;

  // range reduction to the first octant
  logic [1:0]  quad0;
  logic        swap0;
  logic [29:0] rr0;

  always_ff @(posedge clk) begin
    if (en) begin
      quad0 <= angle[31:30];
      swap0 <= angle[29:0] > 30'h2000_0000;
      rr0   <= (angle[29:0] > 30'h2000_0000) ? 30'(Q30_ONE - {1'b0, angle[29:0]})
                                             : angle[29:0];
    end
  end

  // radians
  logic [60:0] xprod;
  logic [1:0]  quad1;
  logic        swap1;
  logic [29:0] x1;

  assign xprod = rr0 * HALF_PI_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      quad1 <= quad0;
      swap1 <= swap0;
      x1    <= 30'((xprod + (61'(1) << (FRAC_Q - 1))) >> FRAC_Q);
    end
  end

  // x squared
  logic [59:0] xsq;
  ctx_t        ctx2;

  assign xsq = x1 * x1;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2.quad <= quad1;
      ctx2.swap <= swap1;
      ctx2.x    <= x1;
      ctx2.x2   <= 30'(xsq >> FRAC_Q);
    end
  end

  // Horner terms: multiply, reciprocal multiply, correct
  ctx_t        ctx_a [SERIES_TERMS];
  ctx_t        ctx_b [SERIES_TERMS];
  ctx_t        ctx_c [SERIES_TERMS];
  logic [29:0] ns_a  [SERIES_TERMS];
  logic [29:0] nc_a  [SERIES_TERMS];
  logic [29:0] ns_b  [SERIES_TERMS];
  logic [29:0] nc_b  [SERIES_TERMS];
  logic [29:0] qs_b  [SERIES_TERMS];
  logic [29:0] qc_b  [SERIES_TERMS];
  logic [30:0] ts_c  [SERIES_TERMS];
  logic [30:0] tc_c  [SERIES_TERMS];

  for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
    ctx_t        ctx_in;
    logic [30:0] ts_in;
    logic [30:0] tc_in;
    logic [60:0] ps;
    logic [60:0] pc;
    logic [60:0] ms;
    logic [60:0] mc;
    logic [29:0] rs;
    logic [29:0] rc;

    if (j == 0) begin : g_first
      assign ctx_in = ctx2;
      assign ts_in  = Q30_ONE;
      assign tc_in  = Q30_ONE;
    end else begin : g_next
      assign ctx_in = ctx_c[j-1];
      assign ts_in  = ts_c[j-1];
      assign tc_in  = tc_c[j-1];
    end

    assign ps = ctx_in.x2 * ts_in;
    assign pc = ctx_in.x2 * tc_in;
    assign ms = ns_a[j] * SIN_RCP[j];
    assign mc = nc_a[j] * COS_RCP[j];
    assign rs = ns_b[j] - 30'(qs_b[j] * SIN_DEN[j]);
    assign rc = nc_b[j] - 30'(qc_b[j] * COS_DEN[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_a[j] <= ctx_in;
        ns_a[j]  <= 30'(ps >> FRAC_Q);
        nc_a[j]  <= 30'(pc >> FRAC_Q);
        ctx_b[j] <= ctx_a[j];
        ns_b[j]  <= ns_a[j];
        nc_b[j]  <= nc_a[j];
        qs_b[j]  <= 30'(ms >> 31);
        qc_b[j]  <= 30'(mc >> 31);
        ctx_c[j] <= ctx_b[j];
        ts_c[j]  <= Q30_ONE - 31'((rs >= 30'(SIN_DEN[j])) ? qs_b[j] + 30'd1 : qs_b[j]);
        tc_c[j]  <= Q30_ONE - 31'((rc >= 30'(COS_DEN[j])) ? qc_b[j] + 30'd1 : qc_b[j]);
      end
    end
  end

  // final sine product
  logic [60:0] sprod;
  logic [1:0]  quadf;
  logic        swapf;
  logic [30:0] smag;
  logic [30:0] cmag;

  assign sprod = ctx_c[SERIES_TERMS-1].x * ts_c[SERIES_TERMS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      quadf <= ctx_c[SERIES_TERMS-1].quad;
      swapf <= ctx_c[SERIES_TERMS-1].swap;
      smag  <= 31'(sprod >> FRAC_Q);
      cmag  <= tc_c[SERIES_TERMS-1];
    end
  end

  // octant swap and quadrant signs
  logic signed [TRIG_W-1:0] s0;
  logic signed [TRIG_W-1:0] c0;
  logic signed [TRIG_W-1:0] s_next;
  logic signed [TRIG_W-1:0] c_next;

  always_comb begin
    s0 = signed'(TRIG_W'(swapf ? cmag : smag));
    c0 = signed'(TRIG_W'(swapf ? smag : cmag));
    case (quad_t'(quadf))
      QUAD_0: begin
        s_next = s0;
        c_next = c0;
      end
      QUAD_1: begin
        s_next = c0;
        c_next = -s0;
      end
      QUAD_2: begin
        s_next = -s0;
        c_next = -c0;
      end
      default: begin
        s_next = -c0;
        c_next = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine   <= s_next;
      cosine <= c_next;
    end
  end

endmodule

// ----- hdl/sphere_vertex_and_strip_index_top.sv -----
// UV-sphere grid point unit. Each item is a grid position (column index in s_tdata[10:0],
// ring index in s_tdata[21:11]); the result is the unit-sphere vertex (Q14 coordinates,
// zero when the column is not below the column count) and the two triangle-strip indices
// (zero when the ring is not below the ring count). One item is accepted per clock; an
// item passes the input register, the angle dividers (44 quotient bits, four per stage),
// the six-term sine/cosine series (three stages per term) and the coordinate stages to
// the output register. A two-entry output stage lets the pipeline keep running while
// one result waits; the input stalls only when both entries are full. Write the column
// and ring counts only while no item is in flight; counts above 1024 are held at 1024.
module sphere_vertex_and_strip_index_top import svsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CNT_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [10:0] column_index, [21:11] ring_index
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [68:48] upper_strip_index,
  // [89:69] lower_strip_index
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [0] vertex_valid, [1] strip_valid
  output logic [OUT_USER_W-1:0] m_tuser
);

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] ring_count;
  logic [CNT_W-1:0] cfg_clamped;

  assign cfg_clamped = (cfg_data > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CNT_W'(32);
      ring_count   <= CNT_W'(16);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COLUMN_COUNT: column_count <= cfg_clamped;
        REG_RING_COUNT:   ring_count   <= cfg_clamped;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // input stage
  logic             in_vld;
  logic [CNT_W-1:0] u_r;
  logic [CNT_W-1:0] v_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= s_tdata[CNT_W-1:0];
      v_r <= s_tdata[2*CNT_W-1:CNT_W];
    end
  end

  // angles as Q32 turn fractions
  logic [CNT_W-1:0]     cdiv;
  logic [CNT_W-1:0]     rdiv;
  logic [DIV_W-1:0]     theta_num;
  logic [DIV_W-1:0]     phi_num;
  logic [ANG_W-1:0]     theta_ang;
  logic [ANG_W-1:0]     phi_ang;

  assign cdiv      = (column_count == '0) ? CNT_W'(1) : column_count;
  assign rdiv      = (ring_count == '0) ? CNT_W'(1) : ring_count;
  assign theta_num = DIV_W'({v_r, 32'h0}) + DIV_W'(rdiv);
  assign phi_num   = DIV_W'({u_r, 32'h0}) + DIV_W'(cdiv >> 1);

  svsi_div u_theta_div (
    .clk      (clk),
    .en       (en),
    .dividend (theta_num),
    .divisor  ({rdiv, 1'b0}),
    .quotient (theta_ang)
  );

  svsi_div u_phi_div (
    .clk      (clk),
    .en       (en),
    .dividend (phi_num),
    .divisor  ({1'b0, cdiv}),
    .quotient (phi_ang)
  );

  logic signed [TRIG_W-1:0] st;
  logic signed [TRIG_W-1:0] ct;
  logic signed [TRIG_W-1:0] sp;
  logic signed [TRIG_W-1:0] cp;

  svsi_sincos u_theta_sc (
    .clk    (clk),
    .en     (en),
    .angle  (theta_ang),
    .sine   (st),
    .cosine (ct)
  );

  svsi_sincos u_phi_sc (
    .clk    (clk),
    .en     (en),
    .angle  (phi_ang),
    .sine   (sp),
    .cosine (cp)
  );

  // coordinates: product, magnitude, round
  logic signed [63:0]       prod_x;
  logic signed [63:0]       prod_z;
  logic signed [TRIG_W-1:0] y1;
  logic [62:0]              mag_x;
  logic [62:0]              mag_z;
  logic [30:0]              mag_y;
  logic                     neg_x;
  logic                     neg_z;
  logic                     neg_y;
  logic [COORD_W-1:0]       pos_x;
  logic [COORD_W-1:0]       pos_y;
  logic [COORD_W-1:0]       pos_z;
  logic [COORD_W-1:0]       rx;
  logic [COORD_W-1:0]       ry;
  logic [COORD_W-1:0]       rz;

  assign rx = COORD_W'((mag_x + (63'(1) << (XZ_SHIFT - 1))) >> XZ_SHIFT);
  assign rz = COORD_W'((mag_z + (63'(1) << (XZ_SHIFT - 1))) >> XZ_SHIFT);
  assign ry = COORD_W'((mag_y + (31'(1) << (Y_SHIFT - 1))) >> Y_SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= st * cp;
      prod_z <= st * sp;
      y1     <= ct;
      neg_x  <= prod_x[63];
      neg_z  <= prod_z[63];
      neg_y  <= y1[TRIG_W-1];
      mag_x  <= prod_x[63] ? 63'(-prod_x) : 63'(prod_x);
      mag_z  <= prod_z[63] ? 63'(-prod_z) : 63'(prod_z);
      mag_y  <= y1[TRIG_W-1] ? 31'(-y1) : 31'(y1);
      pos_x  <= neg_x ? -rx : rx;
      pos_y  <= neg_y ? -ry : ry;
      pos_z  <= neg_z ? -rz : rz;
    end
  end

  // flags and strip indices, delayed alongside the coordinates
  logic             a_vld;
  logic             a_vv;
  logic             a_sv;
  logic [21:0]      a_prod;
  logic [CNT_W-1:0] a_col;
  logic [22:0]      up_sum;
  logic [22:0]      lo_sum;
  side_t            side [SIDE_LEN];

  assign up_sum = 23'(a_prod) + 23'(a_col);
  assign lo_sum = up_sum + 23'(column_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vv   <= u_r < column_count;
      a_sv   <= v_r < ring_count;
      a_prod <= v_r * column_count;
      a_col  <= (u_r == column_count) ? '0 : u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_LEN; i++) begin
        side[i] <= '0;
      end
    end else if (en) begin
      side[0].vld          <= a_vld;
      side[0].vertex_valid <= a_vv;
      side[0].strip_valid  <= a_sv;
      side[0].upper        <= a_sv ? IDX_W'(up_sum) : '0;
      side[0].lower        <= a_sv ? IDX_W'(lo_sum) : '0;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // output register with one skid entry
  side_t                 last;
  logic                  push;
  logic [OUT_DATA_W-1:0] push_tdata;
  logic [OUT_USER_W-1:0] push_tuser;
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic [OUT_DATA_W-1:0] skid_tdata;
  logic [OUT_USER_W-1:0] skid_tuser;

  assign last       = side[SIDE_LEN-1];
  assign push       = last.vld;
  assign push_tdata = {6'd0, last.lower, last.upper,
                       last.vertex_valid ? pos_z : '0,
                       last.vertex_valid ? pos_y : '0,
                       last.vertex_valid ? pos_x : '0};
  assign push_tuser = {last.strip_valid, last.vertex_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!skid_valid) begin
      skid_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_tdata <= skid_valid ? skid_tdata : push_tdata;
      out_tuser <= skid_valid ? skid_tuser : push_tuser;
    end else if (!skid_valid) begin
      skid_tdata <= push_tdata;
      skid_tuser <= push_tuser;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_tdata;
  assign m_tuser  = out_tuser;

endmodule

// ----- hdl/svsi_chk.sv -----
module svsi_chk import svsi_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output item changed");

  a_vertex_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[3*COORD_W-1:0] == '0)
    else $error("position not zero without vertex");

  a_strip_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[3*COORD_W+2*IDX_W-1:3*COORD_W] == '0)
    else $error("strip indices not zero without strip");

endmodule

bind sphere_vertex_and_strip_index_top svsi_chk u_svsi_chk (.*);

// ----- dv/sphere_vertex_and_strip_index_top_tb.sv -----
`timescale 1ns / 100ps

module sphere_vertex_and_strip_index_top_tb;
  import svsi_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic [15:0]      pos_x;
    logic [15:0]      pos_y;
    logic [15:0]      pos_z;
    logic             vertex_valid;
    logic [IDX_W-1:0] upper;
    logic [IDX_W-1:0] lower;
    logic             strip_valid;
  } grid_point_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [0:0]            cfg_index = '0;
  logic [CNT_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  logic [CNT_W-1:0] cols_q, rings_q;
  grid_point_t      points_q[$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  logic             stall_mode = 1'b0;

  sphere_vertex_and_strip_index_top DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] horner(logic [63:0] x2, logic [7:0] den[SERIES_TERMS]);
    logic [63:0] t;
    t = 64'h4000_0000 - x2 / den[0];
    for (int k = 1; k < SERIES_TERMS; k++)
      t = 64'h4000_0000 - ((x2 * t) >> 30) / den[k];
    return t;
  endfunction

  task automatic turn_sin_cos(input logic [31:0] ang, output longint s, output longint c);
    logic [63:0] r, x, x2;
    longint      a, b, s0, c0;
    logic        swap;
    r = {34'd0, ang[29:0]};
    swap = r > 64'h2000_0000;
    if (swap) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713 + 64'h2000_0000) >> 30;
    x2 = (x * x) >> 30;
    a = longint'((x * horner(x2, SIN_DEN)) >> 30);
    b = longint'(horner(x2, COS_DEN));
    s0 = swap ? b : a;
    c0 = swap ? a : b;
    case (quad_t'(ang[31:30]))
      QUAD_0: begin s = s0; c = c0; end
      QUAD_1: begin s = c0; c = -s0; end
      QUAD_2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  function automatic logic [15:0] round_coord(longint v, int sh);
    logic [63:0] m;
    m = v < 0 ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) m = -m;
    return m[15:0];
  endfunction

  task automatic predict_point(input logic [10:0] u, input logic [10:0] v);
    grid_point_t p;
    logic [63:0] cdiv, rdiv, th, ph, up;
    longint      st, ct, sp, cp;
    cdiv = cols_q == 0 ? 1 : cols_q;
    rdiv = rings_q == 0 ? 1 : rings_q;
    th = (({53'd0, v} << 32) + rdiv) / (2 * rdiv);
    ph = (({53'd0, u} << 32) + cdiv / 2) / cdiv;
    turn_sin_cos(th[31:0], st, ct);
    turn_sin_cos(ph[31:0], sp, cp);
    p = '0;
    p.vertex_valid = u < cols_q;
    p.strip_valid = v < rings_q;
    if (p.vertex_valid) begin
      p.pos_x = round_coord(st * cp, XZ_SHIFT);
      p.pos_y = round_coord(ct, Y_SHIFT);
      p.pos_z = round_coord(st * sp, XZ_SHIFT);
    end
    up = v * cols_q + (u == cols_q ? 0 : u);
    if (p.strip_valid) begin
      p.upper = up[IDX_W-1:0];
      p.lower = 21'(up + cols_q);
    end
    points_q.push_back(p);
  endtask

  task automatic write_count(input cfg_reg_t idx, input logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COLUMN_COUNT) cols_q = val > MAX_SEGMENTS ? CNT_W'(MAX_SEGMENTS) : val;
    else rings_q = val > MAX_SEGMENTS ? CNT_W'(MAX_SEGMENTS) : val;
  endtask

  task automatic send_point(input logic [10:0] u, input logic [10:0] v);
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, v, u};
    do @(posedge clk); while (!s_tready);
    predict_point(u, v);
  endtask

  task automatic pause_sender();
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (points_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(input logic [CNT_W-1:0] c, input logic [CNT_W-1:0] r);
    write_count(REG_COLUMN_COUNT, c);
    write_count(REG_RING_COUNT, r);
  endtask

  task automatic test_directed();
    send_point(0, 0);
    send_point(31, 15);
    send_point(32, 15);
    send_point(33, 16);
    send_point(16, 8);
    send_point(8, 4);
    send_point(24, 12);
    send_point(11'h7FF, 11'h7FF);
    send_point(11'h555, 11'h2AA);
    send_point(11'h2AA, 11'h555);
    drain();
    set_counts(11'h7FF, 11'd1024);
    send_point(1023, 1023);
    send_point(1024, 1024);
    send_point(1025, 2000);
    send_point(512, 512);
    drain();
    set_counts(0, 0);
    send_point(0, 0);
    send_point(1, 1);
    send_point(11'h7FF, 5);
    drain();
    set_counts(3, 2);
    for (int i = 0; i < 4; i++) send_point(CNT_W'(i), CNT_W'(i % 3));
    drain();
  endtask

  task automatic test_random_grids();
    logic [CNT_W-1:0] c, r;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin c = 32; r = 16; end
        1: begin c = 3; r = 2; end
        2: begin c = 1024; r = 1024; end
        default: begin
          c = $urandom_range(0, 2) == 0 ? CNT_W'($urandom_range(0, 2047))
                                        : CNT_W'($urandom_range(3, 64));
          r = $urandom_range(0, 2) == 0 ? CNT_W'($urandom_range(0, 2047))
                                        : CNT_W'($urandom_range(2, 64));
        end
      endcase
      set_counts(c, r);
      for (int i = 0; i < 48; i++) begin
        pause_sender();
        if ($urandom_range(0, 7) == 0)
          send_point(CNT_W'($urandom_range(0, 2047)), CNT_W'($urandom_range(0, 2047)));
        else
          send_point(CNT_W'($urandom_range(0, cols_q)), CNT_W'($urandom_range(0, rings_q)));
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      m_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    grid_point_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0],
             m_tdata[68:48], m_tdata[89:69], m_tuser[1]};
      if (points_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
      end else begin
        want = points_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp x=%h y=%h z=%h vv=%b up=%h lo=%h sv=%b",
                     want.pos_x, want.pos_y, want.pos_z, want.vertex_valid, want.upper,
                     want.lower, want.strip_valid);
            $display("         got x=%h y=%h z=%h vv=%b up=%h lo=%h sv=%b",
                     got.pos_x, got.pos_y, got.pos_z, got.vertex_valid, got.upper,
                     got.lower, got.strip_valid);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cols_q = 32;
    rings_q = 16;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_grids();
    if (mismatches == 0 && points_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
